>>> sv/caimu_pkg.sv
// Shared types, constants and micro-program for the IMU lever-arm acceleration block.
`timescale 1ns / 1ps

package caimu_pkg;

  localparam int ACC_W   = 56;  // accumulator width
  localparam int PROD_W  = 66;  // 33 x 33 signed product
  localparam int DVD_W   = 53;  // divider dividend / quotient width
  localparam int NUM_OPS = 27;  // micro-program length
  localparam int OP_W    = $clog2(NUM_OPS);
  localparam int CNT_W   = $clog2(DVD_W);

  localparam logic [2:0] REG_LEVER_X  = 3'd0;
  localparam logic [2:0] REG_LEVER_Y  = 3'd1;
  localparam logic [2:0] REG_LEVER_Z  = 3'd2;
  localparam logic [2:0] REG_GRAVITY  = 3'd3;
  localparam logic [2:0] REG_MIN_STEP = 3'd4;

  localparam logic signed [32:0] US_PER_S = 33'sd1000000;

  // Multiplier operand selects
  typedef enum logic [4:0] {
    OPN_QW, OPN_QX, OPN_QY, OPN_QZ,
    OPN_OM0, OPN_OM1, OPN_OM2,
    OPN_AL0, OPN_AL1, OPN_AL2,
    OPN_S0, OPN_S1, OPN_S2,
    OPN_W0, OPN_W1, OPN_W2,
    OPN_M0, OPN_M1, OPN_M2,
    OPN_G, OPN_NG
  } opnd_t;

  // Rounding shift applied to a product
  typedef enum logic [1:0] {SH16, SH29, SH30} shf_t;

  // Accumulator start value
  typedef enum logic [2:0] {
    INI_KEEP, INI_ZERO, INI_ONE30, INI_F0, INI_F1, INI_F2
  } init_t;

  // Destination of the clipped accumulator
  typedef enum logic [3:0] {
    DST_NONE, DST_M0, DST_M1, DST_M2, DST_W0, DST_W1, DST_W2,
    DST_OUT0, DST_OUT1, DST_OUT2
  } dest_t;

  typedef struct packed {
    opnd_t a;
    opnd_t b;
    shf_t  shf;
    logic  sub;
    init_t init;
    dest_t dest;
  } uop_t;

  // Micro-program: gravity column, inner cross, then the three outputs
  function automatic uop_t caimu_uop(input logic [OP_W-1:0] idx);
    uop_t u;
    u = '{OPN_QW, OPN_QW, SH16, 1'b0, INI_KEEP, DST_NONE};
    unique case (idx)
      5'd0:  u = '{OPN_QX,  OPN_QZ, SH29, 1'b0, INI_ZERO,  DST_NONE};
      5'd1:  u = '{OPN_QW,  OPN_QY, SH29, 1'b0, INI_KEEP,  DST_M0};
      5'd2:  u = '{OPN_QY,  OPN_QZ, SH29, 1'b0, INI_ZERO,  DST_NONE};
      5'd3:  u = '{OPN_QW,  OPN_QX, SH29, 1'b1, INI_KEEP,  DST_M1};
      5'd4:  u = '{OPN_QX,  OPN_QX, SH29, 1'b1, INI_ONE30, DST_NONE};
      5'd5:  u = '{OPN_QY,  OPN_QY, SH29, 1'b1, INI_KEEP,  DST_M2};
      5'd6:  u = '{OPN_OM1, OPN_S2, SH16, 1'b0, INI_ZERO,  DST_NONE};
      5'd7:  u = '{OPN_OM2, OPN_S1, SH16, 1'b1, INI_KEEP,  DST_W0};
      5'd8:  u = '{OPN_OM2, OPN_S0, SH16, 1'b0, INI_ZERO,  DST_NONE};
      5'd9:  u = '{OPN_OM0, OPN_S2, SH16, 1'b1, INI_KEEP,  DST_W1};
      5'd10: u = '{OPN_OM0, OPN_S1, SH16, 1'b0, INI_ZERO,  DST_NONE};
      5'd11: u = '{OPN_OM1, OPN_S0, SH16, 1'b1, INI_KEEP,  DST_W2};
      5'd12: u = '{OPN_NG,  OPN_M0, SH30, 1'b0, INI_F0,    DST_NONE};
      5'd13: u = '{OPN_AL1, OPN_S2, SH16, 1'b1, INI_KEEP,  DST_NONE};
      5'd14: u = '{OPN_AL2, OPN_S1, SH16, 1'b0, INI_KEEP,  DST_NONE};
      5'd15: u = '{OPN_OM1, OPN_W2, SH16, 1'b1, INI_KEEP,  DST_NONE};
      5'd16: u = '{OPN_OM2, OPN_W1, SH16, 1'b0, INI_KEEP,  DST_OUT0};
      5'd17: u = '{OPN_G,   OPN_M1, SH30, 1'b0, INI_F1,    DST_NONE};
      5'd18: u = '{OPN_AL2, OPN_S0, SH16, 1'b1, INI_KEEP,  DST_NONE};
      5'd19: u = '{OPN_AL0, OPN_S2, SH16, 1'b0, INI_KEEP,  DST_NONE};
      5'd20: u = '{OPN_OM2, OPN_W0, SH16, 1'b1, INI_KEEP,  DST_NONE};
      5'd21: u = '{OPN_OM0, OPN_W2, SH16, 1'b0, INI_KEEP,  DST_OUT1};
      5'd22: u = '{OPN_G,   OPN_M2, SH30, 1'b0, INI_F2,    DST_NONE};
      5'd23: u = '{OPN_AL0, OPN_S1, SH16, 1'b1, INI_KEEP,  DST_NONE};
      5'd24: u = '{OPN_AL1, OPN_S0, SH16, 1'b0, INI_KEEP,  DST_NONE};
      5'd25: u = '{OPN_OM0, OPN_W1, SH16, 1'b1, INI_KEEP,  DST_NONE};
      5'd26: u = '{OPN_OM1, OPN_W0, SH16, 1'b0, INI_KEEP,  DST_OUT2};
      default: u = '{OPN_QW, OPN_QW, SH16, 1'b0, INI_KEEP, DST_NONE};
    endcase
    return u;
  endfunction

  // Clip to signed 32 bits; top bit of the result flags a clip
  function automatic logic [32:0] caimu_clip(input logic signed [ACC_W-1:0] v);
    logic [32:0] r;
    if (v > ACC_W'(64'sh7FFFFFFF)) begin
      r = {1'b1, 32'h7FFFFFFF};
    end else if (v < -ACC_W'(64'sh80000000)) begin
      r = {1'b1, 32'h80000000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage

>>> sv/com_accel_from_imu.sv
// Top level: centre-of-mass acceleration from one IMU sample via a shared multiplier.
// When the rate is differentiated, each of the three axes first runs a 53-step
// restoring divide. A new sample is taken only in S_IDLE, after the last one is
// through; the single 33x33 multiplier is shared by all steps and the divider is
// bit-serial. A finished result waits in S_DONE while the output register still
// holds an untaken result.
// Reset (synchronous, rst_n low) restores the register defaults and clears history.
`timescale 1ns / 1ps

module com_accel_from_imu (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [31:0] in_acc_x,
  input  logic signed [31:0] in_acc_y,
  input  logic signed [31:0] in_acc_z,
  input  logic signed [31:0] in_rate_x,
  input  logic signed [31:0] in_rate_y,
  input  logic signed [31:0] in_rate_z,
  input  logic signed [31:0] in_quat_w,
  input  logic signed [31:0] in_quat_x,
  input  logic signed [31:0] in_quat_y,
  input  logic signed [31:0] in_quat_z,
  input  logic [31:0] in_stamp_us,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] out_com_acc_x,
  output logic signed [31:0] out_com_acc_y,
  output logic signed [31:0] out_com_acc_z,
  output logic        out_saturated
);
  import caimu_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_NUM, S_PREP, S_DIV, S_QUOT, S_MAC, S_DONE} state_t;

  state_t state_r;

  logic signed [31:0] lever_r [3];
  logic [30:0] grav_r;
  logic [19:0] min_step_r;
  logic        seen_r;
  logic [31:0] last_stamp_r;
  logic signed [31:0] last_rate_r [3];

  logic signed [31:0] f_r [3];
  logic signed [31:0] rate_r [3];
  logic signed [31:0] qw_r, qx_r, qy_r, qz_r;
  logic signed [32:0] diff_r [3];
  logic [30:0] dt_r;
  logic signed [31:0] alpha_r [3];
  logic signed [31:0] m_r [3];
  logic signed [31:0] w_r [3];
  logic signed [31:0] res_r [3];
  logic        sat_r;

  logic signed [PROD_W-1:0] p_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic [DVD_W-1:0] dvd_r;
  logic [31:0] rem_r;
  logic        neg_r;
  logic [CNT_W-1:0] cnt_r;
  logic [1:0]  idx_r;
  logic [OP_W-1:0] op_r;
  logic        ph_r;

  logic        out_valid_r;
  logic signed [31:0] out_x_r, out_y_r, out_z_r;
  logic        out_sat_r;

  uop_t uop_c;
  logic signed [32:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W:0]   p_ext, rsum;
  logic signed [ACC_W-1:0]  term, base, acc_new;
  logic [32:0] clip_c;
  logic [31:0] rem_sh, rem_nx;
  logic        ge;
  logic [PROD_W-1:0] pmag;
  logic [32:0] qclip_c;
  logic [31:0] d_c;
  logic        do_div_c;

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_com_acc_x = out_x_r;
  assign out_com_acc_y = out_y_r;
  assign out_com_acc_z = out_z_r;
  assign out_saturated = out_sat_r;

  // Select one multiplier operand, body-frame signs applied
  function automatic logic signed [32:0] pick(input opnd_t sel);
    logic signed [32:0] v;
    case (sel)
      OPN_QW:  v = 33'(qw_r);
      OPN_QX:  v = 33'(qx_r);
      OPN_QY:  v = 33'(qy_r);
      OPN_QZ:  v = 33'(qz_r);
      OPN_OM0: v = 33'(rate_r[0]);
      OPN_OM1: v = -33'(rate_r[1]);
      OPN_OM2: v = -33'(rate_r[2]);
      OPN_AL0: v = 33'(alpha_r[0]);
      OPN_AL1: v = -33'(alpha_r[1]);
      OPN_AL2: v = -33'(alpha_r[2]);
      OPN_S0:  v = 33'(lever_r[0]);
      OPN_S1:  v = 33'(lever_r[1]);
      OPN_S2:  v = 33'(lever_r[2]);
      OPN_W0:  v = 33'(w_r[0]);
      OPN_W1:  v = 33'(w_r[1]);
      OPN_W2:  v = 33'(w_r[2]);
      OPN_M0:  v = 33'(m_r[0]);
      OPN_M1:  v = 33'(m_r[1]);
      OPN_M2:  v = 33'(m_r[2]);
      OPN_G:   v = $signed({2'b00, grav_r});
      OPN_NG:  v = -$signed({2'b00, grav_r});
      default: v = '0;
    endcase
    return v;
  endfunction

  // Shared multiplier and its operand selection
  always_comb begin
    uop_c = caimu_uop(op_r);
    if (state_r == S_NUM) begin
      mul_a = diff_r[idx_r];
      mul_b = US_PER_S;
    end else begin
      mul_a = pick(uop_c.a);
      mul_b = pick(uop_c.b);
    end
    prod = mul_a * mul_b;
  end

  // Round the held product, pick the start value and accumulate
  always_comb begin
    p_ext = {p_r[PROD_W-1], p_r};
    rsum  = p_ext;
    term  = '0;
    case (uop_c.shf)
      SH16: begin
        rsum = p_ext + (PROD_W+1)'(1 <<< 15);
        term = ACC_W'(rsum >>> 16);
      end
      SH29: begin
        rsum = p_ext + (PROD_W+1)'(1 <<< 28);
        term = ACC_W'(rsum >>> 29);
      end
      default: begin
        rsum = p_ext + (PROD_W+1)'(1 <<< 29);
        term = ACC_W'(rsum >>> 30);
      end
    endcase
    case (uop_c.init)
      INI_ZERO:  base = '0;
      INI_ONE30: base = ACC_W'(64'sd1073741824);
      INI_F0:    base = ACC_W'(f_r[0]);
      INI_F1:    base = -ACC_W'(f_r[1]);
      INI_F2:    base = -ACC_W'(f_r[2]);
      default:   base = acc_r;
    endcase
    acc_new = uop_c.sub ? (base - term) : (base + term);
    clip_c  = caimu_clip(acc_new);
  end

  // Divider step, numerator magnitude, quotient clip and the time-step check
  always_comb begin
    rem_sh  = {rem_r[30:0], dvd_r[DVD_W-1]};
    ge      = (rem_sh >= {1'b0, dt_r});
    rem_nx  = ge ? (rem_sh - {1'b0, dt_r}) : rem_sh;
    pmag    = p_r[PROD_W-1] ? PROD_W'(-p_r) : PROD_W'(p_r);
    qclip_c = caimu_clip(neg_r ? -ACC_W'(dvd_r) : ACC_W'(dvd_r));
    d_c      = in_stamp_us - last_stamp_r;
    do_div_c = seen_r && ($signed(d_c) > $signed({12'b0, min_step_r}));
  end

  // Hold state, sequence the work and drive the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      lever_r[0]   <= 32'sd10486;
      lever_r[1]   <= 32'sd0;
      lever_r[2]   <= 32'sd5898;
      grav_r       <= 31'd642689;
      min_step_r   <= 20'd100;
      seen_r       <= 1'b0;
      last_stamp_r <= '0;
      for (int i = 0; i < 3; i++) last_rate_r[i] <= '0;
      out_valid_r  <= 1'b0;
      op_r         <= '0;
      ph_r         <= 1'b0;
      idx_r        <= '0;
      cnt_r        <= '0;
      sat_r        <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_we) begin
        unique case (cfg_index)
          REG_LEVER_X:  lever_r[0] <= cfg_wdata;
          REG_LEVER_Y:  lever_r[1] <= cfg_wdata;
          REG_LEVER_Z:  lever_r[2] <= cfg_wdata;
          REG_GRAVITY:  grav_r     <= cfg_wdata[30:0];
          REG_MIN_STEP: min_step_r <= cfg_wdata[19:0];
          default: ;
        endcase
      end

      // drop the result on its transfer unless S_DONE reloads it
      if (out_valid_r && out_ready && state_r != S_DONE) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            f_r[0] <= in_acc_x;  f_r[1] <= in_acc_y;  f_r[2] <= in_acc_z;
            rate_r[0] <= in_rate_x; rate_r[1] <= in_rate_y; rate_r[2] <= in_rate_z;
            qw_r <= in_quat_w; qx_r <= in_quat_x; qy_r <= in_quat_y; qz_r <= in_quat_z;
            diff_r[0] <= 33'(in_rate_x) - 33'(last_rate_r[0]);
            diff_r[1] <= 33'(in_rate_y) - 33'(last_rate_r[1]);
            diff_r[2] <= 33'(in_rate_z) - 33'(last_rate_r[2]);
            last_rate_r[0] <= in_rate_x;
            last_rate_r[1] <= in_rate_y;
            last_rate_r[2] <= in_rate_z;
            last_stamp_r <= in_stamp_us;
            seen_r       <= 1'b1;
            dt_r         <= d_c[30:0];
            for (int i = 0; i < 3; i++) alpha_r[i] <= '0;
            sat_r <= 1'b0;
            idx_r <= '0;
            op_r  <= '0;
            ph_r  <= 1'b0;
            state_r <= do_div_c ? S_NUM : S_MAC;
          end
        end
        S_NUM: begin
          p_r     <= prod;
          state_r <= S_PREP;
        end
        S_PREP: begin
          neg_r   <= p_r[PROD_W-1];
          dvd_r   <= DVD_W'(pmag) + DVD_W'(dt_r >> 1);
          rem_r   <= '0;
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r <= rem_nx;
          dvd_r <= {dvd_r[DVD_W-2:0], ge};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(DVD_W - 1)) state_r <= S_QUOT;
        end
        S_QUOT: begin
          alpha_r[idx_r] <= qclip_c[31:0];
          sat_r <= sat_r | qclip_c[32];
          if (idx_r == 2'd2) begin
            state_r <= S_MAC;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_NUM;
          end
        end
        S_MAC: begin
          if (!ph_r) begin
            p_r  <= prod;
            ph_r <= 1'b1;
          end else begin
            acc_r <= acc_new;
            ph_r  <= 1'b0;
            if (uop_c.dest != DST_NONE) sat_r <= sat_r | clip_c[32];
            case (uop_c.dest)
              DST_M0:   m_r[0]   <= clip_c[31:0];
              DST_M1:   m_r[1]   <= clip_c[31:0];
              DST_M2:   m_r[2]   <= clip_c[31:0];
              DST_W0:   w_r[0]   <= clip_c[31:0];
              DST_W1:   w_r[1]   <= clip_c[31:0];
              DST_W2:   w_r[2]   <= clip_c[31:0];
              DST_OUT0: res_r[0] <= clip_c[31:0];
              DST_OUT1: res_r[1] <= clip_c[31:0];
              DST_OUT2: res_r[2] <= clip_c[31:0];
              default: ;
            endcase
            if (op_r == OP_W'(NUM_OPS - 1)) begin
              state_r <= S_DONE;
            end else begin
              op_r <= op_r + 1'b1;
            end
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_x_r     <= res_r[0];
            out_y_r     <= res_r[1];
            out_z_r     <= res_r[2];
            out_sat_r   <= sat_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
